@@ sv/assert_macros.svh @@
// assertion helpers for the dispatcher rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication checked on the next edge outside reset
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/bpjd_pkg.sv @@
// ------------------------------------------------------------------------
// bpjd_pkg
// shared types and constants of the bounded priority job dispatcher
// ------------------------------------------------------------------------
`default_nettype none
package bpjd_pkg;
  localparam int unsigned PENDING_DEPTH = 16;
  localparam int unsigned QCNT_W = $clog2(PENDING_DEPTH + 1);

  localparam logic [1:0] KIND_SUBMIT = 2'd0;
  localparam logic [1:0] KIND_FINISH = 2'd1;
  localparam logic [1:0] KIND_CANCEL = 2'd2;
  localparam logic [1:0] KIND_LIMIT  = 2'd3;

  localparam logic [1:0] EV_LAUNCHED  = 2'd0;
  localparam logic [1:0] EV_QUEUED    = 2'd1;
  localparam logic [1:0] EV_REJECTED  = 2'd2;
  localparam logic [1:0] EV_CANCELLED = 2'd3;

  // one queue entry
  typedef struct packed {
    logic [15:0] job_id;
    logic signed [7:0] prio;
    logic [15:0] owner;
    logic [31:0] gen;
  } entry_t;

  // chain operation broadcast to every cell
  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2
  } chain_op_t;

  typedef struct packed {
    chain_op_t op;
    entry_t    ent;
    logic [QCNT_W-1:0] pos;
  } chain_cmd_t;
endpackage
`default_nettype wire

@@ sv/bpjd_cell.sv @@
// ------------------------------------------------------------------------
// bpjd_cell
// one slot of the sorted pending chain; shifts with its neighbors
// ------------------------------------------------------------------------
`default_nettype none
module bpjd_cell (
  input  wire logic clk,
  input  wire logic [bpjd_pkg::QCNT_W-1:0] idx,
  input  wire bpjd_pkg::chain_cmd_t cmd,
  input  wire bpjd_pkg::entry_t left_ent,
  input  wire bpjd_pkg::entry_t right_ent,
  output bpjd_pkg::entry_t ent
);
  import bpjd_pkg::*;

  entry_t ent_r, ent_nxt;

  // insert pulls from the left above pos, remove pulls from the right
  always_comb begin
    ent_nxt = ent_r;
    case (cmd.op)
      OP_INSERT: begin
        if (idx == cmd.pos) ent_nxt = cmd.ent;
        else if (idx > cmd.pos) ent_nxt = left_ent;
      end
      OP_REMOVE: begin
        if (idx >= cmd.pos) ent_nxt = right_ent;
      end
      default: ent_nxt = ent_r;
    endcase
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

  assign ent = ent_r;
endmodule
`default_nettype wire

@@ sv/bpjd_chain.sv @@
// ------------------------------------------------------------------------
// bpjd_chain
// row of pending cells with per-cell compare flags
// ------------------------------------------------------------------------
`default_nettype none
module bpjd_chain (
  input  wire logic clk,
  input  wire bpjd_pkg::chain_cmd_t cmd,
  input  wire logic signed [7:0] cmp_prio,
  input  wire logic [15:0] cmp_owner,
  input  wire logic [31:0] cmp_gen,
  output logic [bpjd_pkg::PENDING_DEPTH-1:0] ge_flags,
  output logic [bpjd_pkg::PENDING_DEPTH-1:0] cancel_flags,
  output bpjd_pkg::entry_t cells [bpjd_pkg::PENDING_DEPTH]
);
  import bpjd_pkg::*;

  entry_t left_v [PENDING_DEPTH];
  entry_t right_v [PENDING_DEPTH];

  for (genvar g = 0; g < PENDING_DEPTH; g++) begin : g_cell
    if (g == 0) begin : g_l0
      assign left_v[g] = cmd.ent;
    end else begin : g_ln
      assign left_v[g] = cells[g-1];
    end
    if (g == PENDING_DEPTH - 1) begin : g_rl
      assign right_v[g] = cells[g];
    end else begin : g_rn
      assign right_v[g] = cells[g+1];
    end
    bpjd_cell u_cell (
      .clk(clk), .idx(QCNT_W'(g)), .cmd(cmd),
      .left_ent(left_v[g]), .right_ent(right_v[g]), .ent(cells[g])
    );
    // local compares per cell
    assign ge_flags[g] = (cells[g].prio >= cmp_prio);
    assign cancel_flags[g] = (cells[g].owner == cmp_owner) && (cells[g].gen < cmp_gen);
  end
endmodule
`default_nettype wire

@@ sv/bounded_priority_job_dispatcher.sv @@
// results: a submit result is registered at acceptance; a launch from a finish or a
// limit change is issued from the launch state, one per cycle while the output is free;
// a cancel scans every queued entry; the input stalls while the output is blocked, and
// after a finish, a cancel or a limit change until the dispatcher is back in idle
// reset: counts cleared, limit 1, max_pending 16; queue contents left unset
// ------------------------------------------------------------------------
// bounded_priority_job_dispatcher
// concurrency-limited job dispatcher with a sorted pending cell chain
// ------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module bounded_priority_job_dispatcher (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic in_stall,
  input  wire logic [1:0] in_kind,
  input  wire logic [15:0] in_job_id,
  input  wire logic signed [7:0] in_priority_req,
  input  wire logic [15:0] in_owner,
  input  wire logic [31:0] in_generation,
  input  wire logic [7:0] in_new_limit,
  output logic out_valid,
  input  wire logic out_stall,
  output logic [1:0] out_event_res,
  output logic [15:0] out_out_job_id,
  output logic [7:0] out_active_now,
  output logic [4:0] out_pending_now,
  output logic out_last,
  input  wire logic cfg_psel,
  input  wire logic cfg_penable,
  input  wire logic cfg_pwrite,
  input  wire logic [1:0] cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic cfg_pready
);
  import bpjd_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_LAUNCH, S_CANCEL} state_t;

  state_t state_r;
  logic [4:0] max_pending_r;
  logic [7:0] active_r, limit_r;
  logic [QCNT_W-1:0] qcnt_r, scan_r;
  logic [15:0] own_r;
  logic [31:0] gen_r;
  logic launch_one_r;
  logic got_any_r;
  logic [15:0] hold_id_r;
  logic [4:0] hold_pend_r;
  logic out_valid_r, out_last_r;
  logic [1:0] out_ev_r;
  logic [15:0] out_id_r;
  logic [7:0] out_act_r;
  logic [4:0] out_pend_r;
  logic out_load;

  chain_cmd_t cmd;
  logic [PENDING_DEPTH-1:0] ge_flags, cancel_flags;
  entry_t cells [PENDING_DEPTH];

  // config port
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == 2'd0) ? {27'd0, max_pending_r} : 32'd0;
  wire cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && (cfg_paddr == 2'd0);

  wire out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE) || !out_free;
  wire in_acc = in_valid && !in_stall;

  bpjd_chain u_chain (
    .clk(clk), .cmd(cmd), .cmp_prio(in_priority_req), .cmp_owner(own_r),
    .cmp_gen(gen_r), .ge_flags(ge_flags), .cancel_flags(cancel_flags),
    .cells(cells)
  );

  // insert position: count of valid cells with prio >= new prio (sorted chain)
  logic [QCNT_W-1:0] ins_pos;
  always_comb begin
    ins_pos = '0;
    for (int i = 0; i < PENDING_DEPTH; i++) begin
      if (QCNT_W'(i) < qcnt_r && ge_flags[i]) ins_pos = QCNT_W'(i + 1);
    end
  end

  wire [4:0] cap = (max_pending_r > 5'(PENDING_DEPTH)) ? 5'(PENDING_DEPTH) : max_pending_r;
  wire [7:0] lim_req = (in_new_limit == 8'd0) ? 8'd1 : in_new_limit;
  wire can_launch = (active_r < limit_r) && (qcnt_r != '0);
  wire [QCNT_W-1:0] scan_idx = scan_r - 1'b1;
  wire scan_hit = (scan_r != '0) && cancel_flags[scan_idx[$clog2(PENDING_DEPTH)-1:0]];

  always_comb begin
    cmd.op = OP_HOLD;
    cmd.pos = '0;
    cmd.ent.job_id = in_job_id;
    cmd.ent.prio = in_priority_req;
    cmd.ent.owner = in_owner;
    cmd.ent.gen = in_generation;
    if (state_r == S_IDLE && in_acc && in_kind == KIND_SUBMIT &&
        !(active_r < limit_r) && (5'(qcnt_r) < cap)) begin
      cmd.op = OP_INSERT;
      cmd.pos = ins_pos;
    end else if (state_r == S_LAUNCH && out_free && can_launch) begin
      cmd.op = OP_REMOVE;
    end else if (state_r == S_CANCEL && out_free && scan_r != '0 &&
                 cancel_flags[scan_idx[$clog2(PENDING_DEPTH)-1:0]]) begin
      cmd.op = OP_REMOVE;
      cmd.pos = scan_idx;
    end
  end

  // a new result transaction is loaded this cycle
  always_comb begin
    unique case (state_r)
      S_IDLE: out_load = in_acc && (in_kind == KIND_SUBMIT);
      S_LAUNCH: out_load = out_free && can_launch;
      default: out_load = out_free && got_any_r && ((scan_r == '0) || scan_hit);
    endcase
  end

  // control and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      max_pending_r <= 5'd16;
      active_r <= '0;
      limit_r <= 8'd1;
      qcnt_r <= '0;
      out_valid_r <= 1'b0;
      scan_r <= '0;
      launch_one_r <= 1'b0;
      got_any_r <= 1'b0;
    end else begin
      if (cfg_wr) max_pending_r <= cfg_pwdata[4:0];
      if (out_load) out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            unique case (in_kind)
              KIND_SUBMIT: begin
                out_last_r <= 1'b1;
                out_id_r <= in_job_id;
                if (active_r < limit_r) begin
                  active_r <= active_r + 8'd1;
                  out_act_r <= active_r + 8'd1;
                  out_pend_r <= 5'(qcnt_r);
                  out_ev_r <= EV_LAUNCHED;
                end else if (5'(qcnt_r) < cap) begin
                  qcnt_r <= qcnt_r + 1'b1;
                  out_act_r <= active_r;
                  out_pend_r <= 5'(qcnt_r) + 5'd1;
                  out_ev_r <= EV_QUEUED;
                end else begin
                  out_act_r <= active_r;
                  out_pend_r <= 5'(qcnt_r);
                  out_ev_r <= EV_REJECTED;
                end
              end
              KIND_FINISH: begin
                if (active_r != 8'd0) active_r <= active_r - 8'd1;
                launch_one_r <= 1'b1;
                state_r <= S_LAUNCH;
              end
              KIND_CANCEL: begin
                own_r <= in_owner;
                gen_r <= in_generation;
                scan_r <= qcnt_r;
                got_any_r <= 1'b0;
                state_r <= S_CANCEL;
              end
              default: begin
                if (lim_req != limit_r) begin
                  limit_r <= lim_req;
                  launch_one_r <= 1'b0;
                  state_r <= S_LAUNCH;
                end
              end
            endcase
          end
        end
        S_LAUNCH: begin
          if (out_free) begin
            if (can_launch) begin
              out_ev_r <= EV_LAUNCHED;
              out_id_r <= cells[0].job_id;
              out_act_r <= active_r + 8'd1;
              out_pend_r <= 5'(qcnt_r - 1'b1);
              active_r <= active_r + 8'd1;
              qcnt_r <= qcnt_r - 1'b1;
              // last when no further launch can follow
              out_last_r <= launch_one_r || (active_r + 8'd1 >= limit_r) ||
                            (qcnt_r == QCNT_W'(1));
              if (launch_one_r || (active_r + 8'd1 >= limit_r) ||
                  (qcnt_r == QCNT_W'(1))) state_r <= S_IDLE;
            end else begin
              state_r <= S_IDLE;
            end
          end
        end
        default: begin
          if (out_free) begin
            if (scan_r == '0) begin
              // the held cancel result goes out as the final one
              if (got_any_r) begin
                out_last_r <= 1'b1;
                out_ev_r <= EV_CANCELLED;
                out_id_r <= hold_id_r;
                out_act_r <= active_r;
                out_pend_r <= hold_pend_r;
              end
              state_r <= S_IDLE;
            end else begin
              scan_r <= scan_idx;
              if (scan_hit) begin
                // each match is held until the next one or the end of the scan so the final one can be marked
                if (got_any_r) begin
                  out_last_r <= 1'b0;
                  out_ev_r <= EV_CANCELLED;
                  out_id_r <= hold_id_r;
                  out_act_r <= active_r;
                  out_pend_r <= hold_pend_r;
                end
                got_any_r <= 1'b1;
                hold_id_r <= cells[scan_idx[$clog2(PENDING_DEPTH)-1:0]].job_id;
                hold_pend_r <= 5'(qcnt_r - 1'b1);
                qcnt_r <= qcnt_r - 1'b1;
              end
            end
          end
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_event_res = out_ev_r;
  assign out_out_job_id = out_id_r;
  assign out_active_now = out_act_r;
  assign out_pending_now = out_pend_r;
  assign out_last = out_last_r;

  `ASSERT_CLK(a_qcnt_bound, qcnt_r <= QCNT_W'(PENDING_DEPTH), "queue count above depth")
  `ASSERT_CLK(a_limit_nz, limit_r != 8'd0, "concurrency limit is zero")
  `ASSERT_NEXT(a_busy_stall, state_r != S_IDLE, in_stall || state_r == S_IDLE,
               "input taken while busy")
endmodule
`default_nettype wire

@@ dv/bounded_priority_job_dispatcher_test.sv @@
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// bounded_priority_job_dispatcher_test
// drives submits, finishes, cancels and limit changes through the input
// channel, predicts every launched, queued, rejected and cancelled event
// and compares each result transaction against the prediction
// ------------------------------------------------------------------------
`default_nettype none
module bounded_priority_job_dispatcher_test;
  import bpjd_pkg::*;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [1:0] in_kind;
  logic [15:0] in_job_id;
  logic signed [7:0] in_priority_req;
  logic [15:0] in_owner;
  logic [31:0] in_generation;
  logic [7:0] in_new_limit;
  logic out_valid;
  logic out_stall;
  logic [1:0] out_event_res;
  logic [15:0] out_out_job_id;
  logic [7:0] out_active_now;
  logic [4:0] out_pending_now;
  logic out_last;
  logic cfg_psel;
  logic cfg_penable;
  logic cfg_pwrite;
  logic [1:0] cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  localparam logic [1:0] REG_MAX_PENDING = 2'd0;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [1:0] ev;
    logic [15:0] job_id;
    logic [7:0] active;
    logic [4:0] pending;
    logic last;
  } event_t;

  bounded_priority_job_dispatcher DUT (.*);

  // predictor state
  logic [4:0] pend_cap;
  logic [7:0] active_jobs;
  logic [7:0] run_limit;
  entry_t pend_q[$];
  event_t events_due[$];

  int errors;
  int cycles;
  int checked;
  int hold_cycles;
  bit rx_random;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // runaway guard
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("timeout at %0t", $time);
        $display("FAIL");
        $finish;
      end
    end
  end

  function automatic void push_event(logic [1:0] ev, logic [15:0] id);
    event_t e;
    e.ev = ev;
    e.job_id = id;
    e.active = active_jobs;
    e.pending = 5'(pend_q.size());
    e.last = 1'b0;
    events_due.push_back(e);
  endfunction

  function automatic void start_heads(int most);
    int n;
    n = 0;
    while (n < most && active_jobs < run_limit && pend_q.size() > 0) begin
      entry_t h;
      h = pend_q.pop_front();
      active_jobs++;
      push_event(EV_LAUNCHED, h.job_id);
      n++;
    end
  endfunction

  // advance the dispatcher prediction by one transaction
  function automatic void dispatch_predict(logic [1:0] kind, logic [15:0] id,
                                           logic signed [7:0] prio, logic [15:0] own,
                                           logic [31:0] gen, logic [7:0] lim);
    int before_n;
    int cap;
    int pos;
    entry_t ent;
    logic [7:0] l;
    before_n = events_due.size();
    cap = (pend_cap > PENDING_DEPTH) ? PENDING_DEPTH : pend_cap;
    case (kind)
      KIND_SUBMIT: begin
        if (active_jobs < run_limit) begin
          active_jobs++;
          push_event(EV_LAUNCHED, id);
        end else if (pend_q.size() < cap) begin
          pos = 0;
          while (pos < pend_q.size() && pend_q[pos].prio >= prio) pos++;
          ent.job_id = id;
          ent.prio = prio;
          ent.owner = own;
          ent.gen = gen;
          pend_q.insert(pos, ent);
          push_event(EV_QUEUED, id);
        end else begin
          push_event(EV_REJECTED, id);
        end
      end
      KIND_FINISH: begin
        if (active_jobs > 0) active_jobs--;
        start_heads(1);
      end
      KIND_CANCEL: begin
        for (int i = pend_q.size() - 1; i >= 0; i--) begin
          if (pend_q[i].owner == own && pend_q[i].gen < gen) begin
            ent = pend_q[i];
            pend_q.delete(i);
            push_event(EV_CANCELLED, ent.job_id);
          end
        end
      end
      default: begin
        l = (lim == 0) ? 8'd1 : lim;
        if (l != run_limit) begin
          run_limit = l;
          start_heads(PENDING_DEPTH);
        end
      end
    endcase
    if (events_due.size() > before_n) events_due[$].last = 1'b1;
  endfunction

  // result checker
  initial begin
    event_t e;
    errors = 0;
    checked = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        if (events_due.size() == 0) begin
          $display("%0t unexpected result: got ev %0d id %h", $time, out_event_res,
                   out_out_job_id);
          errors++;
        end else begin
          e = events_due.pop_front();
          checked++;
          if (out_event_res !== e.ev) begin
            $display("%0t event_res expected %0d actual %0d", $time, e.ev, out_event_res);
            errors++;
          end
          if (out_out_job_id !== e.job_id) begin
            $display("%0t job_id expected %h actual %h", $time, e.job_id, out_out_job_id);
            errors++;
          end
          if (out_active_now !== e.active) begin
            $display("%0t active_now expected %0d actual %0d", $time, e.active,
                     out_active_now);
            errors++;
          end
          if (out_pending_now !== e.pending) begin
            $display("%0t pending_now expected %0d actual %0d", $time, e.pending,
                     out_pending_now);
            errors++;
          end
          if (out_last !== e.last) begin
            $display("%0t last expected %0d actual %0d", $time, e.last, out_last);
            errors++;
          end
        end
      end
    end
  end

  // receiver stall: long hold when requested, else random per result
  initial begin
    int w;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        hold_cycles--;
      end else if (rx_random && out_valid && !out_stall) begin
        w = $urandom_range(0, 5);
        if ($urandom_range(0, 3) == 0) w = 0;
        if (w > 0) begin
          out_stall <= 1'b1;
          repeat (w) @(negedge clk);
          out_stall <= 1'b0;
        end
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // one transaction on the input channel; valid stays up until the next call
  // or until wait_idle drops it
  task automatic send_item(logic [1:0] kind, logic [15:0] id, logic signed [7:0] prio,
                           logic [15:0] own, logic [31:0] gen, logic [7:0] lim,
                           bit gaps = 1'b1);
    int w;
    w = gaps ? $urandom_range(0, 5) : 0;
    @(negedge clk);
    if (w > 0) begin
      in_valid <= 1'b0;
      repeat (w) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_job_id <= id;
    in_priority_req <= prio;
    in_owner <= own;
    in_generation <= gen;
    in_new_limit <= lim;
    do @(posedge clk); while (in_stall);
    dispatch_predict(kind, id, prio, own, gen, lim);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (events_due.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_max_pending(logic [4:0] val);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= REG_MAX_PENDING;
    cfg_pwdata <= {27'd0, val};
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    pend_cap = val;
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  // directed extremes and special cases
  task automatic test_directed();
    send_item(KIND_FINISH, 16'h0, 8'sd0, 16'h0, 32'h0, 8'd0);
    send_item(KIND_SUBMIT, 16'hFFFF, 8'sd127, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF);
    send_item(KIND_SUBMIT, 16'h0001, -8'sd128, 16'h0001, 32'h0, 8'h0);
    send_item(KIND_SUBMIT, 16'h0002, 8'sd127, 16'h0001, 32'h5, 8'h0);
    send_item(KIND_SUBMIT, 16'h0003, 8'sd127, 16'h0002, 32'h7, 8'h0);
    send_item(KIND_SUBMIT, 16'h0004, 8'sd0, 16'h0001, 32'hFFFF_FFFE, 8'h0);
    // strict compare: generation equal to threshold stays
    send_item(KIND_CANCEL, 16'hAAAA, 8'sd5, 16'h0001, 32'h5, 8'h0);
    send_item(KIND_CANCEL, 16'h0, 8'sd0, 16'h0001, 32'hFFFF_FFFF, 8'h0);
    send_item(KIND_CANCEL, 16'h0, 8'sd0, 16'h0009, 32'hFFFF_FFFF, 8'h0);
    send_item(KIND_LIMIT, 16'h0, 8'sd0, 16'h0, 32'h0, 8'd0);
    send_item(KIND_LIMIT, 16'h0, 8'sd0, 16'h0, 32'h0, 8'd1);
    send_item(KIND_LIMIT, 16'h0, 8'sd0, 16'h0, 32'h0, 8'd255);
    send_item(KIND_LIMIT, 16'h0, 8'sd0, 16'h0, 32'h0, 8'd1);
    send_item(KIND_FINISH, 16'h0, 8'sd0, 16'h0, 32'h0, 8'd0);
    wait_idle();
    // zero capacity rejects once the limit is reached
    write_max_pending(5'd0);
    send_item(KIND_SUBMIT, 16'h1234, 8'sd1, 16'h3, 32'h1, 8'h0);
    send_item(KIND_SUBMIT, 16'h1235, 8'sd1, 16'h3, 32'h1, 8'h0);
    wait_idle();
    write_max_pending(5'd31);
  endtask

  function automatic logic [31:0] rand_gen();
    case ($urandom_range(0, 3))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      default: return $urandom_range(0, 8) << $urandom_range(0, 28);
    endcase
  endfunction

  // random traffic biased to keep the queue busy
  task automatic run_random(int n, bit gaps);
    int r;
    logic [1:0] k;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      k = (r < 50) ? KIND_SUBMIT : (r < 75) ? KIND_FINISH : (r < 90) ? KIND_CANCEL
          : KIND_LIMIT;
      send_item(k, 16'($urandom), 8'($urandom),
                $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 3)),
                rand_gen(),
                $urandom_range(0, 3) == 0 ? 8'($urandom) : 8'($urandom_range(0, 6)),
                gaps);
    end
  endtask

  task automatic test_random_settings();
    logic [4:0] caps[4] = '{5'd16, 5'd3, 5'd1, 5'd17};
    foreach (caps[i]) begin
      write_max_pending(caps[i]);
      run_random(80, 1'b1);
      wait_idle();
    end
  endtask

  // receiver holds off while the sender keeps pushing
  task automatic test_backpressure();
    write_max_pending(5'd16);
    hold_cycles = 300;
    run_random(60, 1'b0);
    wait_idle();
    rx_random = 1'b0;
    run_random(20, 1'b0);
    wait_idle();
    rx_random = 1'b1;
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_kind = KIND_SUBMIT;
    in_job_id = '0;
    in_priority_req = '0;
    in_owner = '0;
    in_generation = '0;
    in_new_limit = '0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    hold_cycles = 0;
    rx_random = 1'b1;
    pend_cap = 5'd16;
    active_jobs = 8'd0;
    run_limit = 8'd1;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_random_settings();
    test_backpressure();
    wait_idle();
    $display("covered directed extremes, four queue capacities and a long receiver hold");
    $display("%0d results checked, %0d errors", checked, errors);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire
